// ===== rtl/core/mabd_pkg.sv =====
`timescale 1ns / 1ps
// Types, tables and GF(2^4) helpers shared by the Mini-AES decryption block.
package mabd_pkg;

	typedef logic [3:0] nib_t;
	typedef nib_t [3:0] blk_t;

	typedef struct packed {
		logic [3:0] cipher_nib0;
		logic [3:0] cipher_nib1;
		logic [3:0] cipher_nib2;
		logic [3:0] cipher_nib3;
	} cipher_t;

	typedef struct packed {
		logic [3:0] plain_nib0;
		logic [3:0] plain_nib1;
		logic [3:0] plain_nib2;
		logic [3:0] plain_nib3;
	} plain_t;

	typedef struct packed {
		blk_t k0;
		blk_t k1;
		blk_t k2;
	} rkeys_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} pipe_ctl_t;

	localparam int unsigned KEY_W = 16;
	localparam nib_t RCON1 = 4'h1;
	localparam nib_t RCON2 = 4'h2;
	localparam logic [4:0] GF_POLY = 5'h13;

	function automatic nib_t sbox_fwd(input nib_t a);
		nib_t r;
		case (a)
			4'h0: r = 4'hE;
			4'h1: r = 4'h4;
			4'h2: r = 4'hD;
			4'h3: r = 4'h1;
			4'h4: r = 4'h2;
			4'h5: r = 4'hF;
			4'h6: r = 4'hB;
			4'h7: r = 4'h8;
			4'h8: r = 4'h3;
			4'h9: r = 4'hA;
			4'hA: r = 4'h6;
			4'hB: r = 4'hC;
			4'hC: r = 4'h5;
			4'hD: r = 4'h9;
			4'hE: r = 4'h0;
			default: r = 4'h7;
		endcase
		return r;
	endfunction

	function automatic nib_t sbox_inv(input nib_t a);
		nib_t r;
		case (a)
			4'h0: r = 4'hE;
			4'h1: r = 4'h3;
			4'h2: r = 4'h4;
			4'h3: r = 4'h8;
			4'h4: r = 4'h1;
			4'h5: r = 4'hC;
			4'h6: r = 4'hA;
			4'h7: r = 4'hF;
			4'h8: r = 4'h7;
			4'h9: r = 4'hD;
			4'hA: r = 4'h9;
			4'hB: r = 4'h6;
			4'hC: r = 4'hB;
			4'hD: r = 4'h2;
			4'hE: r = 4'h0;
			default: r = 4'h5;
		endcase
		return r;
	endfunction

	function automatic nib_t gf_x2(input nib_t a);
		logic [4:0] r;
		r = {a, 1'b0};
		if (r[4]) begin
			r = r ^ GF_POLY;
		end
		return r[3:0];
	endfunction

	function automatic nib_t gf_x3(input nib_t a);
		return gf_x2(a) ^ a;
	endfunction

	function automatic blk_t next_rkey(input blk_t p, input nib_t rcon);
		blk_t q;
		q[0] = p[0] ^ sbox_fwd(p[3]) ^ rcon;
		q[1] = p[1] ^ q[0];
		q[2] = p[2] ^ q[1];
		q[3] = p[3] ^ q[2];
		return q;
	endfunction

	function automatic rkeys_t derive_keys(input logic [KEY_W-1:0] key);
		rkeys_t rk;
		rk.k0[0] = key[15:12];
		rk.k0[1] = key[11:8];
		rk.k0[2] = key[7:4];
		rk.k0[3] = key[3:0];
		rk.k1 = next_rkey(rk.k0, RCON1);
		rk.k2 = next_rkey(rk.k1, RCON2);
		return rk;
	endfunction

endpackage

// ===== rtl/core/mini_aes_block_decrypt.sv =====
`timescale 1ns / 1ps
// Mini-AES 16-bit block decryption with a three-stage pipeline. One ciphertext beat can
// be taken every clock cycle while the output is not stalled, and each accepted beat
// passes through the register stages s1, s2 and s3 to the plaintext output. A stall on
// the output backs up only as far as there are full stages, so empty stages keep taking
// beats. The user must write the cipher key through cfg_wen and cfg_wdata while no beat
// is in flight, which the block does not enforce; the key is used from the next cycle on.
module mini_aes_block_decrypt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  mabd_pkg::cipher_t          in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output mabd_pkg::plain_t           out_data,
	input  logic                       cfg_wen,
	input  logic [mabd_pkg::KEY_W-1:0] cfg_wdata
);

	mabd_pkg::rkeys_t    rkeys;
	mabd_pkg::pipe_ctl_t ctl;
	logic                valid_s1;
	logic                valid_s2;
	logic                valid_s3;
	logic                ready1;
	logic                ready2;
	logic                ready3;

	assign ready3 = !valid_s3 || !out_stall;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;

	assign ctl.en1 = ready1;
	assign ctl.en2 = ready2;
	assign ctl.en3 = ready3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready1) begin
				valid_s1 <= in_valid;
			end
			if (ready2) begin
				valid_s2 <= valid_s1;
			end
			if (ready3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	mabd_key_sched u_key_sched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.rkeys     (rkeys)
	);

	mabd_datapath u_datapath (
		.clk   (clk),
		.ctl   (ctl),
		.rkeys (rkeys),
		.din   (in_data),
		.dout  (out_data)
	);

	assign in_stall  = !ready1;
	assign out_valid = valid_s3;

endmodule

// ===== rtl/core/mabd_key_sched.sv =====
`timescale 1ns / 1ps
// Key register that expands the cipher key into the three round keys on each write.
module mabd_key_sched (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [mabd_pkg::KEY_W-1:0] cfg_wdata,
	output mabd_pkg::rkeys_t           rkeys
);

	mabd_pkg::rkeys_t rkeys_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rkeys_q <= mabd_pkg::derive_keys('0);
		end else if (cfg_wen) begin
			rkeys_q <= mabd_pkg::derive_keys(cfg_wdata);
		end
	end

	assign rkeys = rkeys_q;

endmodule

// ===== rtl/core/mabd_datapath.sv =====
`timescale 1ns / 1ps
// Three-stage decryption datapath: round 2 undo, key add and column mix, final round.
module mabd_datapath (
	input  logic                clk,
	input  mabd_pkg::pipe_ctl_t ctl,
	input  mabd_pkg::rkeys_t    rkeys,
	input  mabd_pkg::cipher_t   din,
	output mabd_pkg::plain_t    dout
);

	mabd_pkg::blk_t d_in;
	mabd_pkg::blk_t a_nxt;
	mabd_pkg::blk_t b_nxt;
	mabd_pkg::blk_t c_nxt;
	mabd_pkg::blk_t t1;
	mabd_pkg::blk_t t2;
	mabd_pkg::blk_t t3;
	mabd_pkg::blk_t data_s1;
	mabd_pkg::blk_t data_s2;
	mabd_pkg::blk_t data_s3;

	assign d_in[0] = din.cipher_nib0;
	assign d_in[1] = din.cipher_nib1;
	assign d_in[2] = din.cipher_nib2;
	assign d_in[3] = din.cipher_nib3;

	always_comb begin
		t1 = d_in ^ rkeys.k2;
		a_nxt[0] = mabd_pkg::sbox_inv(t1[0]);
		a_nxt[1] = mabd_pkg::sbox_inv(t1[3]);
		a_nxt[2] = mabd_pkg::sbox_inv(t1[2]);
		a_nxt[3] = mabd_pkg::sbox_inv(t1[1]);
	end

	always_comb begin
		t2 = data_s1 ^ rkeys.k1;
		b_nxt[0] = mabd_pkg::gf_x3(t2[0]) ^ mabd_pkg::gf_x2(t2[1]);
		b_nxt[1] = mabd_pkg::gf_x2(t2[0]) ^ mabd_pkg::gf_x3(t2[1]);
		b_nxt[2] = mabd_pkg::gf_x3(t2[2]) ^ mabd_pkg::gf_x2(t2[3]);
		b_nxt[3] = mabd_pkg::gf_x2(t2[2]) ^ mabd_pkg::gf_x3(t2[3]);
	end

	always_comb begin
		t3[0] = mabd_pkg::sbox_inv(data_s2[0]);
		t3[1] = mabd_pkg::sbox_inv(data_s2[3]);
		t3[2] = mabd_pkg::sbox_inv(data_s2[2]);
		t3[3] = mabd_pkg::sbox_inv(data_s2[1]);
		c_nxt = t3 ^ rkeys.k0;
	end

	always_ff @(posedge clk) begin
		if (ctl.en1) begin
			data_s1 <= a_nxt;
		end
		if (ctl.en2) begin
			data_s2 <= b_nxt;
		end
		if (ctl.en3) begin
			data_s3 <= c_nxt;
		end
	end

	assign dout.plain_nib0 = data_s3[0];
	assign dout.plain_nib1 = data_s3[1];
	assign dout.plain_nib2 = data_s3[2];
	assign dout.plain_nib3 = data_s3[3];

endmodule

// ===== rtl/core/mabd_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the decryption block and its bind to the top level.
module mabd_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("Output beat dropped while stalled.");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall)
		else $error("Input stalled without output back pressure.");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("Accepted beat did not reach the output in three cycles.");

	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid && !in_valid) [*3] |=> !out_valid)
		else $error("Output beat appeared too early after an idle input.");

endmodule

bind mini_aes_block_decrypt mabd_checker u_mabd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mini_aes_block_decrypt with directed and random beats.
module testbench;

	typedef logic [mabd_pkg::KEY_W-1:0] key_t;

	localparam int PIPE_LAT    = 3;
	localparam int HOLD_CYCLES = 100;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [63:0] FWD_SUB = 64'h7095C6A3_8BF21D4E;
	localparam logic [63:0] INV_SUB = 64'h502B69D7_FAC1843E;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	mabd_pkg::cipher_t   in_data   = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	mabd_pkg::plain_t    out_data;
	logic                cfg_wen   = 1'b0;
	key_t                cfg_wdata = '0;

	key_t                key_model = '0;
	mabd_pkg::plain_t    plain_q[$];
	mabd_pkg::plain_t    plain_exp;
	int                  errors       = 0;
	int                  blocks_sent  = 0;
	int                  keys_loaded  = 0;
	bit                  tx_idle_en   = 1'b0;
	bit                  rx_idle_en   = 1'b0;
	bit                  hold_req     = 1'b0;

	mini_aes_block_decrypt u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	always #4 clk = ~clk;

	function automatic logic [3:0] sub_fwd(input logic [3:0] a);
		return FWD_SUB[4*a +: 4];
	endfunction

	function automatic logic [3:0] sub_inv(input logic [3:0] a);
		return INV_SUB[4*a +: 4];
	endfunction

	function automatic logic [3:0] gf_dbl(input logic [3:0] a);
		return {a[2:0], 1'b0} ^ (a[3] ? 4'h3 : 4'h0);
	endfunction

	function automatic mabd_pkg::plain_t model_plain(input mabd_pkg::cipher_t blk,
		input key_t key);
		logic [3:0] rk [3][4];
		logic [3:0] d [4];
		logic [3:0] e [4];
		logic [3:0] a, b, t;
		mabd_pkg::plain_t p;
		for (int i = 0; i < 4; i++) begin
			rk[0][i] = key[15-4*i -: 4];
		end
		for (int r = 1; r < 3; r++) begin
			rk[r][0] = rk[r-1][0] ^ sub_fwd(rk[r-1][3]) ^ 4'(r);
			for (int i = 1; i < 4; i++) begin
				rk[r][i] = rk[r-1][i] ^ rk[r][i-1];
			end
		end
		d[0] = blk.cipher_nib0;
		d[1] = blk.cipher_nib1;
		d[2] = blk.cipher_nib2;
		d[3] = blk.cipher_nib3;
		for (int i = 0; i < 4; i++) begin
			e[i] = sub_inv(d[i ^ ((i & 1) << 1)] ^ rk[2][i ^ ((i & 1) << 1)]);
		end
		for (int i = 0; i < 4; i++) begin
			d[i] = e[i] ^ rk[1][i];
		end
		for (int c = 0; c < 4; c += 2) begin
			a = d[c];
			b = d[c+1];
			d[c]   = gf_dbl(a) ^ a ^ gf_dbl(b);
			d[c+1] = gf_dbl(a) ^ gf_dbl(b) ^ b;
		end
		t = d[1];
		d[1] = d[3];
		d[3] = t;
		for (int i = 0; i < 4; i++) begin
			d[i] = sub_inv(d[i]) ^ rk[0][i];
		end
		p.plain_nib0 = d[0];
		p.plain_nib1 = d[1];
		p.plain_nib2 = d[2];
		p.plain_nib3 = d[3];
		return p;
	endfunction

	task automatic check_nib(input string name, input logic [3:0] exp_v,
		input logic [3:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (plain_q.size() == 0) begin
				$display("%0t ns: unexpected plaintext beat, expected none, actual %h",
					$time, out_data);
				errors++;
			end else begin
				plain_exp = plain_q.pop_front();
				check_nib("plain_nib0", plain_exp.plain_nib0, out_data.plain_nib0);
				check_nib("plain_nib1", plain_exp.plain_nib1, out_data.plain_nib1);
				check_nib("plain_nib2", plain_exp.plain_nib2, out_data.plain_nib2);
				check_nib("plain_nib3", plain_exp.plain_nib3, out_data.plain_nib3);
			end
		end
	end

	initial begin : receiver
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 7);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t ns: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_block(input mabd_pkg::cipher_t blk);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		plain_q.push_back(model_plain(blk, key_model));
		blocks_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (plain_q.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	task automatic load_key(input key_t key);
		wait_drained();
		cfg_wen   <= 1'b1;
		cfg_wdata <= key;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		key_model = key;
		keys_loaded++;
	endtask

	task automatic send_corner_blocks();
		send_block(mabd_pkg::cipher_t'(16'h0000));
		send_block(mabd_pkg::cipher_t'(16'hFFFF));
		send_block(mabd_pkg::cipher_t'(16'hF000));
		send_block(mabd_pkg::cipher_t'(16'h0F00));
		send_block(mabd_pkg::cipher_t'(16'h00F0));
		send_block(mabd_pkg::cipher_t'(16'h000F));
		send_block(mabd_pkg::cipher_t'(16'h8421));
		send_block(mabd_pkg::cipher_t'(16'h1248));
	endtask

	task automatic test_reset_key();
		send_corner_blocks();
	endtask

	task automatic test_key_extremes();
		load_key(16'hFFFF);
		send_corner_blocks();
		load_key(16'h8001);
		send_corner_blocks();
	endtask

	task automatic test_random_traffic();
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0:       load_key(16'hA5A5);
				1:       load_key(16'h5A5A);
				default: load_key(key_t'($urandom));
			endcase
			repeat (50) send_block(mabd_pkg::cipher_t'(16'($urandom)));
		end
	endtask

	task automatic test_output_hold();
		load_key(key_t'($urandom));
		tx_idle_en = 1'b0;
		hold_req   = 1'b1;
		repeat (40) send_block(mabd_pkg::cipher_t'(16'($urandom)));
		tx_idle_en = 1'b1;
	endtask

	task automatic test_streaming();
		load_key(16'h0000);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		repeat (60) send_block(mabd_pkg::cipher_t'(16'($urandom)));
		wait_drained();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_key_extremes();
		test_random_traffic();
		test_output_hold();
		test_streaming();
		repeat (PIPE_LAT + 4) @(posedge clk);
		if (plain_q.size() != 0) begin
			$display("%0t ns: %0d plaintext beats never arrived", $time, plain_q.size());
			errors++;
		end
		$display("Decrypted %0d blocks under %0d written keys plus the reset key,",
			blocks_sent, keys_loaded);
		$display("with random gaps and stalls and one %0d-cycle output hold.", HOLD_CYCLES);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
